// ===== hw/rtl/spbg_pkg.sv =====
`default_nettype none

package spbg_pkg;

  localparam int unsigned TICK_W    = 10;
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned PERIODS_W = 10;
  localparam int unsigned ELAPSED_W = 17;
  localparam int unsigned HIGH_W    = 12;
  localparam int unsigned ANGLE_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_US       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_US      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_PERIODS = 2'd2;

  localparam logic [TICK_W-1:0]    TICK_US_RESET       = 10'd100;
  localparam logic [FRAME_W-1:0]   FRAME_US_RESET      = 16'd20000;
  localparam logic [PERIODS_W-1:0] BURST_PERIODS_RESET = 10'd40;
  localparam logic [HIGH_W-1:0]    HIGH_US_RESET       = 12'd1500;
  localparam logic [FRAME_W-1:0]   LOW_US_RESET        = 16'd18500;

  localparam logic [ANGLE_W-1:0]   ANGLE_MAX   = 8'd180;
  localparam logic [HIGH_W-1:0]    HIGH_BASE   = 12'd500;
  // 100/9 in 16-bit fixed point, rounded up so truncation matches exactly
  localparam int unsigned          SCALE_W     = 28;
  localparam logic [SCALE_W-1:0]   SCALE_MULT  = 28'd728178;
  localparam int unsigned          SCALE_SHIFT = 16;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [PERIODS_W-1:0] PULSES_MAX  = '1;

endpackage

`default_nettype wire

// ===== hw/rtl/spbg_pulse_calc.sv =====
`default_nettype none

module spbg_pulse_calc (
  input  wire logic [spbg_pkg::ANGLE_W-1:0] angle,
  input  wire logic [spbg_pkg::FRAME_W-1:0] frame_us,
  output logic      [spbg_pkg::HIGH_W-1:0]  high_us,
  output logic      [spbg_pkg::FRAME_W-1:0] low_us
);

  logic [spbg_pkg::ANGLE_W-1:0] deg;
  logic [spbg_pkg::SCALE_W-1:0] scaled;
  logic [spbg_pkg::FRAME_W-1:0] high_wide;

  always_comb begin
    deg = (angle > spbg_pkg::ANGLE_MAX) ? spbg_pkg::ANGLE_MAX : angle;
    scaled = {{(spbg_pkg::SCALE_W-spbg_pkg::ANGLE_W){1'b0}}, deg} * spbg_pkg::SCALE_MULT;
    high_us = spbg_pkg::HIGH_BASE
            + scaled[spbg_pkg::SCALE_SHIFT +: spbg_pkg::HIGH_W];
    high_wide = {{(spbg_pkg::FRAME_W-spbg_pkg::HIGH_W){1'b0}}, high_us};
    low_us = (frame_us > high_wide) ? (frame_us - high_wide) : '0;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/servo_pulse_burst_gen.sv =====
`default_nettype none

// Servo pulse burst generator.
// Input channel (in_valid/in_stall): one word per event; action = 1 sets a
// new angle and starts a burst with the pin high, action = 0 is one timer
// tick of tick_us microseconds. Output channel (out_valid/out_stall): one
// word per input word, giving the pin level and running flag after it.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; index 0
// tick_us, 1 frame_us, 2 burst_periods, index 3 is ignored. Write only while
// the block is idle.
// An accepted word passes through the input register and then the result
// register. Throughput: one word per cycle while the receiver does not stall;
// the input register and the result register form a two-stage pipe, and all
// per-word math is one clamp, one constant multiply, adds, a subtract and compares.
// Receiver stall: the result holds, the input register fills, then in_stall
// rises; nothing is dropped.
// Reset: config returns to 100 us / 20000 us / 40 pulses, the burst is
// stopped, the pin is low and both pipe stages are empty.
module servo_pulse_burst_gen (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               action,
  input  wire logic [spbg_pkg::ANGLE_W-1:0]       angle,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    pin_level,
  output logic                                    running,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [spbg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [spbg_pkg::FRAME_W-1:0]       cfg_data
);

  logic [spbg_pkg::TICK_W-1:0]    tick_us;
  logic [spbg_pkg::FRAME_W-1:0]   frame_us;
  logic [spbg_pkg::PERIODS_W-1:0] burst_periods;

  logic                           in_full;
  logic                           in_action;
  logic [spbg_pkg::ANGLE_W-1:0]   in_angle;

  logic [spbg_pkg::ELAPSED_W-1:0] elapsed_us;
  logic                           in_high_phase;
  logic [spbg_pkg::PERIODS_W-1:0] pulses_sent;
  logic [spbg_pkg::HIGH_W-1:0]    pulse_high_us;
  logic [spbg_pkg::FRAME_W-1:0]   pulse_low_us;
  logic                           active;
  logic                           pin_out;

  logic [spbg_pkg::ELAPSED_W-1:0] elapsed_us_next;
  logic                           in_high_phase_next;
  logic [spbg_pkg::PERIODS_W-1:0] pulses_sent_next;
  logic [spbg_pkg::HIGH_W-1:0]    pulse_high_us_next;
  logic [spbg_pkg::FRAME_W-1:0]   pulse_low_us_next;
  logic                           active_next;
  logic                           pin_out_next;

  logic                           advance;
  logic                           in_accept;
  logic                           step;
  logic [spbg_pkg::HIGH_W-1:0]    calc_high;
  logic [spbg_pkg::FRAME_W-1:0]   calc_low;
  logic [spbg_pkg::ELAPSED_W:0]   sum;
  logic [spbg_pkg::ELAPSED_W-1:0] sat;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_full && !advance;
  assign in_accept = in_valid && !in_stall;
  assign step      = in_full && advance;
  assign pin_level = pin_out;
  assign running   = active;

  spbg_pulse_calc u_calc (
    .angle    (in_angle),
    .frame_us (frame_us),
    .high_us  (calc_high),
    .low_us   (calc_low)
  );

  always_comb begin
    elapsed_us_next    = elapsed_us;
    in_high_phase_next = in_high_phase;
    pulses_sent_next   = pulses_sent;
    pulse_high_us_next = pulse_high_us;
    pulse_low_us_next  = pulse_low_us;
    active_next        = active;
    pin_out_next       = pin_out;
    sum = {1'b0, elapsed_us}
        + {{(spbg_pkg::ELAPSED_W+1-spbg_pkg::TICK_W){1'b0}}, tick_us};
    sat = sum[spbg_pkg::ELAPSED_W] ? spbg_pkg::ELAPSED_MAX
                                   : sum[spbg_pkg::ELAPSED_W-1:0];
    if (in_action) begin
      pulse_high_us_next = calc_high;
      pulse_low_us_next  = calc_low;
      elapsed_us_next    = '0;
      in_high_phase_next = 1'b1;
      pulses_sent_next   = '0;
      active_next        = 1'b1;
      pin_out_next       = 1'b1;
    end else if (active) begin
      elapsed_us_next = sat;
      if (in_high_phase) begin
        if (sat >= {{(spbg_pkg::ELAPSED_W-spbg_pkg::HIGH_W){1'b0}}, pulse_high_us}) begin
          if (pulses_sent != spbg_pkg::PULSES_MAX) begin
            pulses_sent_next = pulses_sent + 1'b1;
          end
          pin_out_next       = 1'b0;
          in_high_phase_next = 1'b0;
          elapsed_us_next    = '0;
        end
      end else begin
        if (sat >= {{(spbg_pkg::ELAPSED_W-spbg_pkg::FRAME_W){1'b0}}, pulse_low_us}) begin
          pin_out_next       = 1'b1;
          in_high_phase_next = 1'b1;
          elapsed_us_next    = '0;
        end
      end
      if (pulses_sent_next >= burst_periods) begin
        active_next  = 1'b0;
        pin_out_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_us       <= spbg_pkg::TICK_US_RESET;
      frame_us      <= spbg_pkg::FRAME_US_RESET;
      burst_periods <= spbg_pkg::BURST_PERIODS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spbg_pkg::CFG_TICK_US:       tick_us       <= cfg_data[spbg_pkg::TICK_W-1:0];
        spbg_pkg::CFG_FRAME_US:      frame_us      <= cfg_data;
        spbg_pkg::CFG_BURST_PERIODS: burst_periods <= cfg_data[spbg_pkg::PERIODS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_action <= action;
      in_angle  <= angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full       <= 1'b0;
      out_valid     <= 1'b0;
      elapsed_us    <= '0;
      in_high_phase <= 1'b0;
      pulses_sent   <= '0;
      pulse_high_us <= spbg_pkg::HIGH_US_RESET;
      pulse_low_us  <= spbg_pkg::LOW_US_RESET;
      active        <= 1'b0;
      pin_out       <= 1'b0;
    end else begin
      in_full <= in_accept || (in_full && !advance);
      if (advance) begin
        out_valid <= in_full;
      end
      if (step) begin
        elapsed_us    <= elapsed_us_next;
        in_high_phase <= in_high_phase_next;
        pulses_sent   <= pulses_sent_next;
        pulse_high_us <= pulse_high_us_next;
        pulse_low_us  <= pulse_low_us_next;
        active        <= active_next;
        pin_out       <= pin_out_next;
      end
    end
  end

  // a stopped burst always leaves the pin low
  assert property (@(posedge clk) disable iff (rst) !active |-> !pin_out)
    else $error("pin high while stopped");

  // while running the pin follows the phase
  assert property (@(posedge clk) disable iff (rst) active |-> (pin_out == in_high_phase))
    else $error("pin and phase disagree");

  // a new result only appears after a word sat in the input register
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(in_full))
    else $error("result without input word");

endmodule

`default_nettype wire
